### rtl/psft_pkg.sv
// ----------------------------------------------------------------------------
// psft_pkg
// Shared types and codes for the publish/subscribe fan-out table.
// ----------------------------------------------------------------------------
package psft_pkg;

    // Default sizing of the table
    localparam int TOPICS_DEF = 128;
    localparam int SLOTS_DEF  = 16;

    // Input operation codes
    localparam logic OP_SUBSCRIBE = 1'b0;
    localparam logic OP_PUBLISH   = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_OK   = 2'd0;
    localparam logic [1:0] KIND_FULL = 2'd1;
    localparam logic [1:0] KIND_COPY = 2'd2;

    // Sender id used on replies
    localparam logic [15:0] KERNEL_ID = 16'd1;

    // Command word
    typedef struct packed {
        logic        opcode;
        logic [6:0]  topic;
        logic [15:0] sender_id;
        logic [63:0] payload;
    } cmd_word_t;

    // Message word
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] receiver_id;
        logic [15:0] from_id;
        logic [63:0] body;
        logic        last;
    } msg_word_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY
    } state_t;

endpackage

### rtl/psft_ram.sv
// ----------------------------------------------------------------------------
// psft_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module psft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/publish_subscribe_fanout_table_unit.sv
// ----------------------------------------------------------------------------
// publish_subscribe_fanout_table_unit
// Per-topic subscriber lists with subscribe replies and publish fan-out.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one command word at a
//   time: subscribe appends the sender to the topic's list, publish fans the
//   payload out to every subscriber of the topic in subscription order.
//   msg channel (msg_valid / msg_stall / msg) gives one reply word for a
//   subscribe (ok or full) and one copy word per subscriber for a publish,
//   with last set on the final word. A publish to an empty or unknown topic
//   gives nothing.
//   A subscribe reply goes to the output register once the count memory
//   read is done and that register is free; a publish copy passes through
//   a list memory read and the output register, one copy a cycle while
//   msg_stall is low, from the single read port of the list memory. A new
//   command is taken only in idle: after the reply, or after the last copy
//   is in the output register. After reset a clearing pass zeroes the count
//   memory; cmd_stall is high meanwhile. A stalled output word is held in
//   the output register and the fan-out pauses, losing nothing.
// ----------------------------------------------------------------------------
module publish_subscribe_fanout_table_unit #(
    parameter int TOPICS = psft_pkg::TOPICS_DEF,
    parameter int SLOTS  = psft_pkg::SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  psft_pkg::cmd_word_t cmd,
    output logic                msg_valid,
    input  logic                msg_stall,
    output psft_pkg::msg_word_t msg
);

    localparam int TW = (TOPICS > 1) ? $clog2(TOPICS) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] FULL_CNT  = SW'(SLOTS - 1);
    localparam logic [TW-1:0] LAST_TOPIC = TW'(TOPICS - 1);

    psft_pkg::state_t state_reg, state_next;

    logic [TW-1:0]        clr_reg, clr_next;
    logic [SW-1:0]        cnt_reg, cnt_next;
    logic [SW-1:0]        issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic                 pend_last_reg, pend_last_next;
    logic                 out_valid_reg, out_valid_next;
    psft_pkg::msg_word_t  out_data_reg, out_data_next;
    psft_pkg::cmd_word_t  cmd_reg;

    // Memory ports
    logic                 cnt_we, cnt_re;
    logic [TW-1:0]        cnt_waddr, cnt_raddr;
    logic [SW-1:0]        cnt_wdata, cnt_rd;
    logic                 lst_we, lst_re;
    logic [TW+SW-1:0]     lst_waddr, lst_raddr;
    logic [15:0]          lst_rd;

    logic                 cmd_take;
    logic                 out_free;
    logic                 in_range;
    logic [TW-1:0]        topic_idx;
    logic                 move;
    logic                 do_read;

    psft_ram #(.WIDTH(SW), .DEPTH(TOPICS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rd)
    );

    psft_ram #(.WIDTH(16), .DEPTH(TOPICS << SW)) u_lst_ram (
        .clk   (clk),
        .we    (lst_we),
        .waddr (lst_waddr),
        .wdata (cmd_reg.sender_id),
        .re    (lst_re),
        .raddr (lst_raddr),
        .rdata (lst_rd)
    );

    // Handshake
    assign cmd_stall = (state_reg != psft_pkg::ST_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign out_free  = !out_valid_reg || !msg_stall;
    assign msg_valid = out_valid_reg;
    assign msg       = out_data_reg;

    // Topic decode of the held command
    assign topic_idx = TW'(cmd_reg.topic);
    assign in_range  = (32'(cmd_reg.topic) < 32'(TOPICS));

    // Fan-out pacing: the list read register is the stage before the output
    assign move    = (state_reg == psft_pkg::ST_COPY) && pend_reg && out_free;
    assign do_read = (state_reg == psft_pkg::ST_COPY) && (issue_reg != cnt_reg)
                     && (!pend_reg || move);

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg && msg_stall;
        out_data_next  = out_data_reg;

        cnt_we    = 1'b0;
        cnt_waddr = clr_reg;
        cnt_wdata = '0;
        cnt_re    = cmd_take;
        cnt_raddr = TW'(cmd.topic);
        lst_we    = 1'b0;
        lst_waddr = {topic_idx, cnt_rd};
        lst_re    = do_read;
        lst_raddr = {topic_idx, issue_reg};

        case (state_reg)
            psft_pkg::ST_CLEAR:
            begin
                cnt_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_TOPIC)
                begin
                    state_next = psft_pkg::ST_IDLE;
                end
            end
            psft_pkg::ST_IDLE:
            begin
                if (cmd_take)
                begin
                    state_next = psft_pkg::ST_READ;
                end
            end
            psft_pkg::ST_READ:
            begin
                if (cmd_reg.opcode == psft_pkg::OP_SUBSCRIBE)
                begin
                    // Reply once the output register is free
                    if (out_free)
                    begin
                        out_valid_next           = 1'b1;
                        out_data_next.receiver_id = cmd_reg.sender_id;
                        out_data_next.from_id    = psft_pkg::KERNEL_ID;
                        out_data_next.body       = '0;
                        out_data_next.last       = 1'b1;
                        if (in_range && (cnt_rd < FULL_CNT))
                        begin
                            out_data_next.kind = psft_pkg::KIND_OK;
                            lst_we    = 1'b1;
                            cnt_we    = 1'b1;
                            cnt_waddr = topic_idx;
                            cnt_wdata = cnt_rd + 1'b1;
                        end
                        else
                        begin
                            out_data_next.kind = psft_pkg::KIND_FULL;
                        end
                        state_next = psft_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    // Publish: empty or unknown topic gives nothing
                    if (!in_range || (cnt_rd == '0))
                    begin
                        state_next = psft_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_next       = (cnt_rd > FULL_CNT) ? FULL_CNT : cnt_rd;
                        issue_next     = '0;
                        pend_next      = 1'b0;
                        pend_last_next = 1'b0;
                        state_next     = psft_pkg::ST_COPY;
                    end
                end
            end
            psft_pkg::ST_COPY:
            begin
                // Pending list word to the output register
                if (move)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.kind        = psft_pkg::KIND_COPY;
                    out_data_next.receiver_id = lst_rd;
                    out_data_next.from_id     = cmd_reg.sender_id;
                    out_data_next.body        = cmd_reg.payload;
                    out_data_next.last        = pend_last_reg;
                    pend_next                 = 1'b0;
                    if (pend_last_reg)
                    begin
                        state_next = psft_pkg::ST_IDLE;
                    end
                end
                // Next list read
                if (do_read)
                begin
                    issue_next     = issue_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = ((issue_reg + 1'b1) == cnt_reg);
                end
            end
            default:
            begin
                state_next = psft_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psft_pkg::ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
        out_data_reg <= out_data_next;
    end

    // Checks
    a_pend_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psft_pkg::ST_COPY && pend_reg) |-> (issue_reg != '0))
        else $error("pending list word without a read issued");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psft_pkg::ST_COPY) |-> (issue_reg <= cnt_reg))
        else $error("fan-out read beyond subscriber count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psft_pkg::ST_READ && in_range) |-> (cnt_rd <= FULL_CNT))
        else $error("stored subscriber count above capacity");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        lst_we |-> (cnt_rd < FULL_CNT && state_reg == psft_pkg::ST_READ))
        else $error("list append into a full topic");

endmodule
